@@ hdl/rc4_stream_cipher_top_macros.svh @@
// Assertion helpers shared by the RC4 cipher modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RC4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rc4_pkg.sv @@
package rc4_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TOP    = 3'd4;

  // Key storage: 32 bytes in four 64-bit registers.
  localparam int REG_KEY_BYTES = 32;
  localparam int KEY_LEN_W     = 6;

  // S-box geometry.
  localparam int SBOX_DEPTH = 256;
  localparam int BYTE_W     = 8;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WN,
    ST_KS_WJ,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_RD_K,
    ST_OUT
  } ctl_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_FILL,
    OP_KS_RD,
    OP_KS_J,
    OP_KS_WN,
    OP_KS_WJ,
    OP_RD_I,
    OP_RD_J,
    OP_WR_I,
    OP_WR_J,
    OP_RD_K,
    OP_OUT
  } dp_op_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   sched;  // with OP_CAPTURE: clear counters and indices for a key schedule
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cnt_last;  // step counter is at its final S-box entry
  } dp_stat_t;

endpackage

@@ hdl/rc4_stream_cipher_top.sv @@
// RC4 byte cipher; the same operation encrypts and decrypts. Load the key length and
// key bytes through the configuration port while the block is idle. There is one S-box
// memory access per cycle: read S[i], read S[j], two swap writes and the keystream read,
// then the output load. A byte with msg_start set, or the first byte after reset, first
// runs the key schedule: it fills the S-box with identity, then runs the permutation
// steps, each reading S[n] and S[j] and writing the swapped pair. One byte is processed
// at a time. The result sits in an output register, so the next byte is accepted while
// a result waits to be taken.
module rc4_stream_cipher_top #(
  parameter int KEY_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                msg_start,
  input  logic [7:0]                          data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_byte
);

  rc4_pkg::dp_cmd_t  cmd;
  rc4_pkg::dp_stat_t stat;

  // Sequencer.
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .msg_start (msg_start),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // S-box, indices, key registers and output register.
  rc4_dpath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (data_byte),
    .out_byte  (out_byte),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ hdl/rc4_ctrl.sv @@
`include "rc4_stream_cipher_top_macros.svh"

module rc4_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               msg_start,
  output logic               out_valid,
  input  logic               out_stall,
  output rc4_pkg::dp_cmd_t   cmd,
  input  rc4_pkg::dp_stat_t  stat
);

  rc4_pkg::ctl_state_t state, state_next;
  logic keyed, keyed_next;
  logic out_valid_next;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::ST_IDLE;
      keyed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      keyed     <= keyed_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequencing of the key schedule and of one data byte.
  always_comb begin
    state_next     = state;
    keyed_next     = keyed;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    cmd.op         = rc4_pkg::OP_NONE;
    cmd.sched      = 1'b0;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = rc4_pkg::OP_CAPTURE;
          if (msg_start || !keyed) begin
            cmd.sched  = 1'b1;
            state_next = rc4_pkg::ST_FILL;
          end else begin
            state_next = rc4_pkg::ST_RD_I;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        cmd.op = rc4_pkg::OP_FILL;
        if (stat.cnt_last) begin
          state_next = rc4_pkg::ST_KS_RD;
        end
      end
      rc4_pkg::ST_KS_RD: begin
        cmd.op     = rc4_pkg::OP_KS_RD;
        state_next = rc4_pkg::ST_KS_J;
      end
      rc4_pkg::ST_KS_J: begin
        cmd.op     = rc4_pkg::OP_KS_J;
        state_next = rc4_pkg::ST_KS_WN;
      end
      rc4_pkg::ST_KS_WN: begin
        cmd.op     = rc4_pkg::OP_KS_WN;
        state_next = rc4_pkg::ST_KS_WJ;
      end
      rc4_pkg::ST_KS_WJ: begin
        cmd.op = rc4_pkg::OP_KS_WJ;
        if (stat.cnt_last) begin
          keyed_next = 1'b1;
          state_next = rc4_pkg::ST_RD_I;
        end else begin
          state_next = rc4_pkg::ST_KS_RD;
        end
      end
      rc4_pkg::ST_RD_I: begin
        cmd.op     = rc4_pkg::OP_RD_I;
        state_next = rc4_pkg::ST_RD_J;
      end
      rc4_pkg::ST_RD_J: begin
        cmd.op     = rc4_pkg::OP_RD_J;
        state_next = rc4_pkg::ST_WR_I;
      end
      rc4_pkg::ST_WR_I: begin
        cmd.op     = rc4_pkg::OP_WR_I;
        state_next = rc4_pkg::ST_WR_J;
      end
      rc4_pkg::ST_WR_J: begin
        cmd.op     = rc4_pkg::OP_WR_J;
        state_next = rc4_pkg::ST_RD_K;
      end
      rc4_pkg::ST_RD_K: begin
        cmd.op     = rc4_pkg::OP_RD_K;
        state_next = rc4_pkg::ST_OUT;
      end
      rc4_pkg::ST_OUT: begin
        // Load the output register once it is free or being drained.
        if (!out_valid || !out_stall) begin
          cmd.op         = rc4_pkg::OP_OUT;
          out_valid_next = 1'b1;
          state_next     = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // A new result appears only when the byte sequence has finished.
  `RC4_ASSERT_SAME(a_out_from_seq, $rose(out_valid), $past(state) == rc4_pkg::ST_OUT, "result without byte sequence")
  // Once keyed, the S-box stays keyed until reset.
  `RC4_ASSERT_NEXT(a_keyed_sticky, keyed, keyed, "keyed flag dropped")
  // A data byte is never processed on an unwritten S-box.
  `RC4_ASSERT_SAME(a_keyed_before_use, state == rc4_pkg::ST_RD_I, keyed, "byte processed before key schedule")
  // A pending result that is held back keeps the sequencer waiting.
  `RC4_ASSERT_NEXT(a_out_wait, state == rc4_pkg::ST_OUT && out_valid && out_stall, state == rc4_pkg::ST_OUT, "result overwritten while stalled")

endmodule

@@ hdl/rc4_dpath.sv @@
module rc4_dpath #(
  parameter int KEY_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [rc4_pkg::BYTE_W-1:0]          data_byte,
  output logic [rc4_pkg::BYTE_W-1:0]          out_byte,
  input  rc4_pkg::dp_cmd_t                    cmd,
  output rc4_pkg::dp_stat_t                   stat
);

  localparam int KW = rc4_pkg::KEY_LEN_W;
  localparam int BW = rc4_pkg::BYTE_W;
  localparam logic [8:0] KEY_BYTES_W = 9'(KEY_BYTES);

  // Configuration registers.
  logic [KW-1:0]                       key_length;
  logic [rc4_pkg::REG_KEY_BYTES*BW-1:0] key_flat;

  // S-box memory with registered read.
  logic [BW-1:0] sbox [rc4_pkg::SBOX_DEPTH];
  logic [BW-1:0] rd_q;
  logic [BW-1:0] rd_addr, wr_addr, wr_data;
  logic          rd_en, wr_en;

  // Indices, counters and holding registers.
  logic [BW-1:0] index_i, index_j;
  logic [BW-1:0] step_n;
  logic [BW-1:0] sched_j;
  logic [KW-1:0] key_idx;
  logic [BW-1:0] hold_a, hold_b;
  logic [BW-1:0] data_q;

  logic [KW-1:0] len_raw, len_used;
  logic [BW-1:0] key_byte;
  logic [BW-1:0] sched_j_next;
  logic [BW-1:0] index_i_next, index_j_next;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KW'(1);
      key_flat   <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        rc4_pkg::REG_KEY_LENGTH: key_length <= cfg_data[KW-1:0];
        rc4_pkg::REG_KEY_LO:     key_flat[0*64 +: 64] <= cfg_data;
        rc4_pkg::REG_KEY_MID:    key_flat[1*64 +: 64] <= cfg_data;
        rc4_pkg::REG_KEY_HI:     key_flat[2*64 +: 64] <= cfg_data;
        rc4_pkg::REG_KEY_TOP:    key_flat[3*64 +: 64] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective key length: zero counts as one, saturate at the key size.
  always_comb begin
    len_raw  = (key_length == '0) ? KW'(1) : key_length;
    len_used = ({3'b000, len_raw} > KEY_BYTES_W) ? KW'(KEY_BYTES) : len_raw;
  end

  // Key byte at the current key position; positions past the registers read zero.
  assign key_byte = key_idx[KW-1] ? '0 : key_flat[key_idx[KW-2:0]*BW +: BW];

  assign sched_j_next = sched_j + rd_q + key_byte;
  assign index_i_next = index_i + BW'(1);
  assign index_j_next = index_j + rd_q;

  assign stat.cnt_last = (step_n == '1);

  // Memory address and write selection per operation.
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = step_n;
    wr_addr = step_n;
    wr_data = rd_q;
    unique case (cmd.op)
      rc4_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_data = step_n;
      end
      rc4_pkg::OP_KS_RD: begin
        rd_en = 1'b1;
      end
      rc4_pkg::OP_KS_J: begin
        rd_en   = 1'b1;
        rd_addr = sched_j_next;
      end
      rc4_pkg::OP_KS_WN: begin
        wr_en = 1'b1;
      end
      rc4_pkg::OP_KS_WJ: begin
        wr_en   = 1'b1;
        wr_addr = sched_j;
        wr_data = hold_a;
      end
      rc4_pkg::OP_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = index_i_next;
      end
      rc4_pkg::OP_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = index_j_next;
      end
      rc4_pkg::OP_WR_I: begin
        wr_en   = 1'b1;
        wr_addr = index_i;
      end
      rc4_pkg::OP_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = index_j;
        wr_data = hold_a;
      end
      rc4_pkg::OP_RD_K: begin
        rd_en   = 1'b1;
        rd_addr = hold_a + hold_b;
      end
      default: ;
    endcase
  end

  // S-box write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbox[wr_addr] <= wr_data;
    end
  end

  // S-box read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= sbox[rd_addr];
    end
  end

  // Cipher indices and schedule counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= '0;
      index_j <= '0;
      step_n  <= '0;
      sched_j <= '0;
      key_idx <= '0;
    end else begin
      unique case (cmd.op)
        rc4_pkg::OP_CAPTURE: begin
          if (cmd.sched) begin
            index_i <= '0;
            index_j <= '0;
            step_n  <= '0;
            sched_j <= '0;
            key_idx <= '0;
          end
        end
        rc4_pkg::OP_FILL: begin
          step_n <= step_n + BW'(1);
        end
        rc4_pkg::OP_KS_J: begin
          sched_j <= sched_j_next;
        end
        rc4_pkg::OP_KS_WJ: begin
          step_n  <= step_n + BW'(1);
          key_idx <= ((key_idx + KW'(1)) == len_used) ? '0 : key_idx + KW'(1);
        end
        rc4_pkg::OP_RD_I: begin
          index_i <= index_i_next;
        end
        rc4_pkg::OP_RD_J: begin
          index_j <= index_j_next;
        end
        default: ;
      endcase
    end
  end

  // Payload holding registers and the output register.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rc4_pkg::OP_CAPTURE: data_q   <= data_byte;
      rc4_pkg::OP_KS_J:    hold_a   <= rd_q;
      rc4_pkg::OP_RD_J:    hold_a   <= rd_q;
      rc4_pkg::OP_WR_I:    hold_b   <= rd_q;
      rc4_pkg::OP_OUT:     out_byte <= data_q ^ rd_q;
      default: ;
    endcase
  end

endmodule

@@ tb/tb_rc4_stream_cipher_top.sv @@
module tb_rc4_stream_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BYTES = 32;
  localparam int MAX_GAP = 18;
  localparam int RANDOM_ITEMS = 600;
  localparam logic [rc4_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = rc4_pkg::REG_KEY_TOP + 1'b1;
  localparam logic [rc4_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  // Tracks the cipher state as requests are accepted and holds the bytes still owed.
  class rc4_scoreboard;
    bit [7:0] perm[rc4_pkg::SBOX_DEPTH];
    bit [7:0] idx_i;
    bit [7:0] idx_j;
    bit keyed;
    bit [rc4_pkg::KEY_LEN_W-1:0] key_len;
    bit [rc4_pkg::CFG_DATA_W-1:0] key_regs[4];
    bit [7:0] cipher_q[$];
    int errors;

    function new();
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b0;
      key_len = rc4_pkg::KEY_LEN_W'(1);
      foreach (key_regs[n]) key_regs[n] = '0;
      errors = 0;
    endfunction

    // Indexes beyond the key registers are dropped, as the block does.
    function void write_reg(bit [rc4_pkg::CFG_IDX_W-1:0] idx,
                            bit [rc4_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rc4_pkg::REG_KEY_LENGTH: key_len = val[rc4_pkg::KEY_LEN_W-1:0];
        rc4_pkg::REG_KEY_LO: key_regs[0] = val;
        rc4_pkg::REG_KEY_MID: key_regs[1] = val;
        rc4_pkg::REG_KEY_HI: key_regs[2] = val;
        rc4_pkg::REG_KEY_TOP: key_regs[3] = val;
        default: ;
      endcase
    endfunction

    // Identity fill, then the key permutation with a zero or oversized length clamped.
    function void schedule();
      int len;
      int b;
      bit [7:0] jj;
      bit [7:0] t;
      len = (key_len == 0) ? 1 : (key_len > KEY_BYTES) ? KEY_BYTES : key_len;
      jj = '0;
      for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) perm[n] = n[7:0];
      for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
        b = n % len;
        jj = jj + perm[n] +
             ((b < rc4_pkg::REG_KEY_BYTES) ? key_regs[b / 8][8 * (b % 8) +: 8] : 8'h00);
        t = perm[n];
        perm[n] = perm[jj];
        perm[jj] = t;
      end
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b1;
    endfunction

    // A byte arriving before any schedule has run forces one.
    function void note_request(bit start, bit [7:0] data);
      bit [7:0] t;
      bit [7:0] k;
      if (start || !keyed) schedule();
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      k = perm[idx_i] + perm[idx_j];
      cipher_q.insert(cipher_q.size(), data ^ perm[k]);
    endfunction

    function void check_result(bit [7:0] got);
      bit [7:0] want;
      if (cipher_q.size() == 0) begin
        $error("out_byte: no request pending, actual %02h", got);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (got !== want) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic msg_start = 1'b0;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;

  rc4_scoreboard sb = new();
  bit idle_on = 1'b1;
  int sent = 0;

  rc4_stream_cipher_top #(
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .msg_start(msg_start),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte)
  );

  always #1 clk = ~clk;

  // Present one request after a random gap and hold it until the block takes it.
  task automatic send_byte(input bit start, input bit [7:0] data);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    msg_start <= start;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    sb.note_request(start, data);
    sent++;
  endtask

  // Hold off new requests until every owed byte has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(input logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Every key register, plus one write to an unused index that must be ignored.
  task automatic load_key(input logic [rc4_pkg::KEY_LEN_W-1:0] len,
                          input logic [rc4_pkg::CFG_DATA_W-1:0] k0,
                          input logic [rc4_pkg::CFG_DATA_W-1:0] k1,
                          input logic [rc4_pkg::CFG_DATA_W-1:0] k2,
                          input logic [rc4_pkg::CFG_DATA_W-1:0] k3);
    write_cfg(rc4_pkg::REG_KEY_LENGTH, {$urandom, $urandom} & ~64'(6'h3f) | 64'(len));
    write_cfg(rc4_pkg::REG_KEY_LO, k0);
    write_cfg(rc4_pkg::REG_KEY_MID, k1);
    write_cfg(rc4_pkg::REG_KEY_HI, k2);
    write_cfg(rc4_pkg::REG_KEY_TOP, k3);
    write_cfg(rc4_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // Random key setting that often lands on the length and value extremes.
  task automatic random_key();
    logic [rc4_pkg::KEY_LEN_W-1:0] len;
    logic [rc4_pkg::CFG_DATA_W-1:0] k[4];
    int style;
    case ($urandom_range(0, 5))
      0: len = '0;
      1: len = rc4_pkg::KEY_LEN_W'(1);
      2: len = rc4_pkg::KEY_LEN_W'(KEY_BYTES);
      3: len = '1;
      default: len = rc4_pkg::KEY_LEN_W'($urandom_range(1, KEY_BYTES));
    endcase
    style = $urandom_range(0, 3);
    foreach (k[n]) k[n] = (style == 0) ? '0 : (style == 1) ? '1 : {$urandom, $urandom};
    load_key(len, k[0], k[1], k[2], k[3]);
  endtask

  // One message: a restart byte and its followers, with the odd stray restart inside.
  task automatic send_message(input int len);
    for (int n = 0; n < len; n++)
      send_byte((n == 0) || ($urandom_range(0, 31) == 0), 8'($urandom));
  endtask

  // Result side: random stalls, then take the next result.
  task automatic collect_results();
    int hold;
    forever begin
      hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_byte);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_results();
    join_none

    // Bytes before any schedule, with the reset key, then an explicit restart.
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hff);
    send_byte(1'b1, 8'h5a);
    send_byte(1'b0, 8'h81);

    // A zero key length behaves as one byte.
    drain();
    load_key('0, '1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    send_byte(1'b1, 8'ha5);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hff);

    // Full-length key over all four registers.
    drain();
    load_key(rc4_pkg::KEY_LEN_W'(KEY_BYTES), {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    send_message(5);

    // Oversized length saturates to the register key size.
    drain();
    load_key('1, '1, '0, '1, {$urandom, $urandom});
    send_message(3);

    // A new key only takes effect at the next restart.
    drain();
    load_key(rc4_pkg::KEY_LEN_W'(5), {$urandom, $urandom}, '0, '0, '0);
    send_byte(1'b0, 8'h3c);
    send_byte(1'b0, 8'hc3);
    send_byte(1'b1, 8'h7e);
    send_byte(1'b0, 8'h01);

    // Random phases: new key while idle, then mostly whole messages.
    while (sent < RANDOM_ITEMS) begin
      drain();
      idle_on = ($urandom_range(0, 3) != 0);
      random_key();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom));
      repeat ($urandom_range(1, 4))
        send_message(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ rc4_stream_cipher_top.f @@
+incdir+hdl
hdl/rc4_pkg.sv
hdl/rc4_ctrl.sv
hdl/rc4_dpath.sv
hdl/rc4_stream_cipher_top.sv
tb/tb_rc4_stream_cipher_top.sv
